// ===== hdl/short_press_double_click_classifier_macros.svh =====
// Assertion macros for the short-press / double-click classifier.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SHORT_PRESS_DOUBLE_CLICK_CLASSIFIER_MACROS_SVH
`define SHORT_PRESS_DOUBLE_CLICK_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
// Implication property checked on the rising clock edge, disabled while in reset.
`define SPDC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("spdc assertion failed");
// Condition that must never be seen on a rising clock edge outside reset.
`define SPDC_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("spdc forbidden condition seen");
`else
`define SPDC_ASSERT(label, clk, rstn, prop)
`define SPDC_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

// ===== hdl/spdc_pkg.sv =====
// Shared types and constants of the short-press / double-click classifier.
// No dependencies; imported by every module of the block.
package spdc_pkg;

  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned ItemWidth     = 4;
  localparam int unsigned ResultWidth   = 3;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutDataWidth  = 8;

  localparam logic [CfgWidth-1:0] DebounceReset    = 16'd10;
  localparam logic [CfgWidth-1:0] DoubleClickReset = 16'd500;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEBOUNCE     = 1'b0,
    REG_DOUBLE_CLICK = 1'b1
  } reg_index_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_EVENT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2
  } click_e;

  // Packed with the first field in the highest bit.
  typedef struct packed {
    logic short_flag;
    logic release_flag;
    logic press_flag;
    op_e  operation;
  } item_t;

  typedef struct packed {
    logic   key_held;
    click_e click_event;
  } result_t;

  // Configuration write request from the top level to the core.
  typedef struct packed {
    logic                     we;
    reg_index_e               index;
    logic [CfgWidth-1:0]      data;
  } cfg_wr_t;

endpackage

// ===== hdl/spdc_pipe_reg.sv =====
// Single pipeline register stage with valid/ready flow control.
// Depends on spdc_pkg only for the common import convention.
module spdc_pipe_reg
  import spdc_pkg::*;
#(
  parameter int unsigned Width = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             load;

  // The stage refills in the same cycle as its content is taken.
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hdl/spdc_core.sv =====
// Classifier state, configuration registers and the single-pass update logic.
// Depends on spdc_pkg and the assertion macro header.
`include "short_press_double_click_classifier_macros.svh"

module spdc_core
  import spdc_pkg::*;
#(
  parameter int unsigned TickCountWidth = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t result_o
);

  // Counters and registers are compared at the wider of the two widths.
  localparam int unsigned CmpWidth =
    (TickCountWidth > CfgWidth) ? TickCountWidth : CfgWidth;
  localparam logic [TickCountWidth-1:0] CntMax = {TickCountWidth{1'b1}};

  logic [CfgWidth-1:0]       debounce_q, double_click_q;
  logic [TickCountWidth-1:0] since_last_q, since_last_d;
  logic [TickCountWidth-1:0] since_first_q, since_first_d;
  logic                      pending_q, pending_d;
  logic                      held_q, held_d;

  logic [TickCountWidth-1:0] since_last_inc, since_first_inc;
  logic                      debounced;
  logic                      window_open;
  logic                      window_expired;
  click_e                    click;

  assign since_last_inc  = (since_last_q == CntMax) ? CntMax : since_last_q + 1'b1;
  assign since_first_inc = (since_first_q == CntMax) ? CntMax : since_first_q + 1'b1;

  assign debounced = CmpWidth'(since_last_q) < CmpWidth'(debounce_q);
  // Window test on the current count, as seen by a key event.
  assign window_open = CmpWidth'(since_first_q) < CmpWidth'(double_click_q);
  // Expiry test on the advanced count, as seen by a tick.
  assign window_expired = CmpWidth'(since_first_inc) >= CmpWidth'(double_click_q);

  always_comb begin
    since_last_d  = since_last_q;
    since_first_d = since_first_q;
    pending_d     = pending_q;
    held_d        = held_q;
    click         = CLICK_NONE;
    unique case (item_i.operation)
      OP_TICK: begin
        since_last_d  = since_last_inc;
        since_first_d = since_first_inc;
        if (pending_q && window_expired) begin
          click         = CLICK_SINGLE;
          pending_d     = 1'b0;
          since_first_d = '0;
        end
      end
      OP_EVENT: begin
        since_last_d = '0;
        if (!debounced) begin
          // Release is applied after press, so both together end released.
          if (item_i.press_flag) begin
            held_d = 1'b1;
          end
          if (item_i.release_flag) begin
            held_d = 1'b0;
          end
          if (item_i.short_flag) begin
            since_first_d = '0;
            if (!pending_q) begin
              pending_d = 1'b1;
            end else if (window_open) begin
              click     = CLICK_DOUBLE;
              pending_d = 1'b0;
            end else begin
              click = CLICK_SINGLE;
            end
          end
        end
      end
      default: begin
        since_last_d = since_last_q;
      end
    endcase
  end

  assign result_o.click_event = click;
  assign result_o.key_held    = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_last_q  <= CntMax;
      since_first_q <= '0;
      pending_q     <= 1'b0;
      held_q        <= 1'b0;
    end else if (en_i) begin
      since_last_q  <= since_last_d;
      since_first_q <= since_first_d;
      pending_q     <= pending_d;
      held_q        <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= DebounceReset;
      double_click_q <= DoubleClickReset;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        REG_DEBOUNCE:     debounce_q     <= cfg_i.data;
        REG_DOUBLE_CLICK: double_click_q <= cfg_i.data;
        default:          debounce_q     <= debounce_q;
      endcase
    end
  end

  `SPDC_ASSERT(a_double_needs_window, clk_i, rst_ni,
               en_i && (click == CLICK_DOUBLE) |-> pending_q)
  `SPDC_ASSERT(a_double_closes_window, clk_i, rst_ni,
               en_i && (click == CLICK_DOUBLE) |=> !pending_q && (since_first_q == '0))
  `SPDC_ASSERT(a_state_holds_when_idle, clk_i, rst_ni,
               !en_i |=> $stable(since_last_q) && $stable(pending_q) && $stable(held_q))
  `SPDC_ASSERT(a_tick_advances, clk_i, rst_ni,
               en_i && (item_i.operation == OP_TICK) && (since_last_q != CntMax)
               |=> since_last_q == $past(since_last_q) + 1'b1)
  `SPDC_ASSERT_NEVER(a_ignored_event_clicks, clk_i, rst_ni,
                     en_i && (item_i.operation == OP_EVENT) && debounced &&
                     (click != CLICK_NONE))

endmodule

// ===== hdl/short_press_double_click_classifier.sv =====
// Top level of the short-press / double-click classifier: input stage, core, output stage.
// Depends on spdc_pkg, spdc_pipe_reg and spdc_core.
//
//   channel   direction  width       contents
//   s_axis    in         8 + 1 user  key flags, tick or event kind in tuser
//   m_axis    out        8           click classification and held level
//   cfg       in         16          debounce and double-click window registers
//
// One transaction is accepted per cycle while m_axis is not stalled; each produces exactly one result.
// Each transaction passes through the input register, then the single-pass update into the
// output register.
// Reset clears the stage valid bits and the classifier state; registers return to
// a debounce of 10 ticks and a window of 500 ticks.
// A stalled output stage holds its result while the input stage can still take one
// more transaction.
module short_press_double_click_classifier
  import spdc_pkg::*;
#(
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] press_flag, [1] release_flag, [2] short_flag, [7:3] zero
  input  logic [InDataWidth-1:0]   s_axis_tdata,
  // [0] operation
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] click_event, [2] key_held, [7:3] zero
  output logic [OutDataWidth-1:0]  m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i
);

  logic                 item_valid;
  logic                 item_ready;
  logic [ItemWidth-1:0] in_item;
  item_t                item;
  result_t              result;
  result_t              result_q;
  cfg_wr_t              cfg_wr;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.index = reg_index_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  // The operation sits in the lowest bit of the stored item, the flags above it.
  assign in_item = {s_axis_tdata[ItemWidth-2:0], s_axis_tuser};

  spdc_pipe_reg #(
    .Width(ItemWidth)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (in_item),
    .out_valid_o(item_valid),
    .out_ready_i(item_ready),
    .out_data_o (item)
  );

  spdc_core #(
    .TickCountWidth(TICK_COUNT_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_wr),
    .en_i    (item_valid && item_ready),
    .item_i  (item),
    .result_o(result)
  );

  spdc_pipe_reg #(
    .Width(ResultWidth)
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_valid),
    .in_ready_o (item_ready),
    .in_data_i  (result),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (result_q)
  );

  assign m_axis_tdata = {{(OutDataWidth-ResultWidth){1'b0}}, result_q};

endmodule
